/* rtl/core/tosc_pkg.sv */
// Package for the tone oscillator: register and item codes, fixed-point constants,
// and the elaboration-time functions that build the sine/cosine/tangent tables.
// No dependencies.
`default_nettype none

package tosc_pkg;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_WAVE_TYPE    = 2'd0;
	localparam logic [1:0] REG_RAMP_SAMPLES = 2'd1;
	localparam logic [1:0] REG_RAMP_STEP    = 2'd2;

	// item kinds
	localparam logic [1:0] KIND_TICK     = 2'd0;
	localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
	localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

	localparam logic [1:0] WAVE_SINE    = 2'd0;

	localparam logic [63:0] PI_Q30    = 64'd3373259426;
	localparam logic [63:0] ONE_Q30   = 64'd1073741824;
	localparam int          MAG_W     = 47;          // tangent magnitude up to 2^46
	localparam int          SC_W      = 32;          // sin/cos magnitude, Q.30
	localparam logic [MAG_W-1:0] TAN_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};
	localparam logic [14:0] FULL_SCALE = 15'd32767;
	localparam logic [15:0] LEVEL_ONE  = 16'd32768;

	// Taylor series, every product truncated; only used at elaboration
	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] acc;
		x2   = (x * x) >> 30;
		term = x;
		acc  = signed'(x);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k[0]) acc = acc - signed'(term);
			else      acc = acc + signed'(term);
		end
		return (acc < 0) ? 64'd0 : unsigned'(acc);
	endfunction

	function automatic logic [63:0] cos_q30(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] acc;
		x2   = (x * x) >> 30;
		term = ONE_Q30;
		acc  = signed'(ONE_Q30);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k[0]) acc = acc - signed'(term);
			else      acc = acc + signed'(term);
		end
		return (acc < 0) ? 64'd0 : unsigned'(acc);
	endfunction

	// quadrant angle for offset r, with a full wave of 2^abits entries
	function automatic logic [63:0] quarter_angle(input int r, input int abits);
		return (64'(r) * PI_Q30) >> (abits - 1);
	endfunction

	// tangent magnitude for address a below the pole, clamped
	function automatic logic [MAG_W-1:0] tan_mag(input int a, input int abits);
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] c;
		logic [63:0] t;
		logic [63:0] num;
		logic [63:0] rem;
		x = (64'(a) * PI_Q30) >> abits;
		s = sin_q30(x);
		c = cos_q30(x);
		t = 64'd0;
		if (c == 64'd0) begin
			t = 64'(TAN_LIMIT);
		end else begin
			// restoring long division of s * 2^30 by c
			num = s << 30;
			rem = 64'd0;
			for (int i = 63; i >= 0; i--) begin
				rem = {rem[62:0], num[i]};
				if (rem >= c) begin
					rem  = rem - c;
					t[i] = 1'b1;
				end
			end
		end
		if (t > 64'(TAN_LIMIT)) t = 64'(TAN_LIMIT);
		return MAG_W'(t);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/tone_oscillator_with_envelope.sv */
// Tone oscillator with linear attack/release envelope: phase accumulator, table
// lookup (sine or tangent), level scaling. Uses tosc_pkg.
// A tick word passes stage 1, 2 and 3 and the output register; one item per
// cycle while the output is not stalled. Up to 4 samples are in flight; with
// the output stalled the input takes words until all 4 are full.
// Reset (arst_n low): envelope silent, phase/step/level cleared, registers at defaults.
`default_nettype none

module tone_oscillator_with_envelope #(
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10,
	parameter int RAMP_COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// items
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] phase_step,
	// samples
	output logic             sample_valid,
	input  wire logic        sample_ready,
	output logic signed [15:0] sample,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int AB  = TABLE_ADDR_BITS;
	localparam int QN  = 2 ** (AB - 2);
	localparam int HN  = 2 ** (AB - 1);
	localparam int MW  = tosc_pkg::MAG_W;
	localparam int SW  = tosc_pkg::SC_W;
	localparam int RCB = RAMP_COUNT_BITS;
	localparam int CW  = (RCB > 16) ? RCB : 16;  // compare width for count load

	typedef enum logic [1:0] {
		MODE_SILENT,
		MODE_ATTACK,
		MODE_SUSTAIN,
		MODE_RELEASE
	} mode_t;

	// ---------------- tables ----------------
	logic [SW-1:0] sin_rom [QN];
	logic [SW-1:0] cos_rom [QN];
	logic [MW-1:0] tan_rom [HN];

	for (genvar i = 0; i < QN; i++) begin : g_sc
		localparam logic [63:0] XA = tosc_pkg::quarter_angle(i, AB);
		localparam logic [63:0] SV = tosc_pkg::sin_q30(XA);
		localparam logic [63:0] CV = tosc_pkg::cos_q30(XA);
		assign sin_rom[i] = SW'(SV);
		assign cos_rom[i] = SW'(CV);
	end

	for (genvar i = 0; i < HN; i++) begin : g_tan
		localparam logic [MW-1:0] TV = tosc_pkg::tan_mag(i, AB);
		assign tan_rom[i] = TV;
	end

	// ---------------- configuration ----------------
	logic        wave_type_q;
	logic [15:0] ramp_samples_q;
	logic [15:0] ramp_step_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q    <= 1'b1;
			ramp_samples_q <= 16'd960;
			ramp_step_q    <= 16'd34;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				tosc_pkg::REG_WAVE_TYPE:    wave_type_q    <= pwdata[0];
				tosc_pkg::REG_RAMP_SAMPLES: ramp_samples_q <= pwdata[15:0];
				tosc_pkg::REG_RAMP_STEP:    ramp_step_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			tosc_pkg::REG_WAVE_TYPE:    prdata = {31'd0, wave_type_q};
			tosc_pkg::REG_RAMP_SAMPLES: prdata = {16'd0, ramp_samples_q};
			tosc_pkg::REG_RAMP_STEP:    prdata = {16'd0, ramp_step_q};
			default:                    prdata = 32'd0;
		endcase
	end

	// ---------------- pipeline handshake ----------------
	logic v_s1, v_s2, v_s3;
	logic rdy_out, rdy3, rdy2, rdy1;
	logic acc;

	assign rdy_out    = !sample_valid | sample_ready;
	assign rdy3       = !v_s3 | rdy_out;
	assign rdy2       = !v_s2 | rdy3;
	assign rdy1       = !v_s1 | rdy2;
	assign item_ready = rdy1;
	assign acc        = item_valid & item_ready;

	// ---------------- envelope and phase ----------------
	mode_t                 mode_q, mode_d;
	logic [RCB-1:0]        left_q, left_d;
	logic [15:0]           level_q, level_d;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] step_q;
	logic [RCB-1:0]        load_cnt;
	logic [16:0]           level_up;

	localparam logic [CW-1:0] CMAX = CW'((64'd1 << RCB) - 64'd1);

	always_comb begin
		if (CW'(ramp_samples_q) > CMAX) load_cnt = CMAX[RCB-1:0];
		else                            load_cnt = RCB'(CW'(ramp_samples_q));
	end

	assign level_up = {1'b0, level_q} + {1'b0, ramp_step_q};

	// envelope move for a tick
	always_comb begin
		mode_d  = mode_q;
		left_d  = left_q;
		level_d = level_q;
		case (mode_q)
			MODE_ATTACK: begin
				if (left_q != '0) begin
					level_d = level_up[16] ? 16'hFFFF : level_up[15:0];
					left_d  = left_q - RCB'(1);
				end else begin
					level_d = tosc_pkg::LEVEL_ONE;
					mode_d  = MODE_SUSTAIN;
				end
			end
			MODE_RELEASE: begin
				if (left_q != '0) begin
					level_d = (level_q > ramp_step_q) ? level_q - ramp_step_q : 16'd0;
					left_d  = left_q - RCB'(1);
				end else begin
					level_d = 16'd0;
					mode_d  = MODE_SILENT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SILENT;
			left_q  <= '0;
			level_q <= '0;
			phase_q <= '0;
			step_q  <= '0;
		end else if (acc) begin
			case (kind)
				tosc_pkg::KIND_NOTE_ON: begin
					step_q  <= PHASE_BITS'(phase_step);
					phase_q <= '0;
					mode_q  <= MODE_ATTACK;
					left_q  <= load_cnt;
					level_q <= '0;
				end
				tosc_pkg::KIND_NOTE_OFF: begin
					mode_q <= MODE_RELEASE;
					left_q <= load_cnt;
				end
				tosc_pkg::KIND_TICK: begin
					mode_q  <= mode_d;
					left_q  <= left_d;
					level_q <= level_d;
					if (mode_d != MODE_SILENT) phase_q <= phase_q + step_q;
				end
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: address, level ----------------
	logic [AB-1:0] addr_s1;
	logic [15:0]   level_s1;
	logic          mute_s1;
	logic          wave_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			addr_s1  <= phase_q[PHASE_BITS-1 -: AB];
			level_s1 <= level_d;
			mute_s1  <= (mode_d == MODE_SILENT);
			wave_s1  <= wave_type_q;
		end
	end

	// ---------------- stage 2: table lookup ----------------
	logic [MW-1:0] mag_d;
	logic          neg_d;
	logic [AB-2:0] tan_idx;
	logic [AB-1:0] addr_neg;
	logic [MW-1:0] mag_s2;
	logic          neg_s2;
	logic [15:0]   level_s2;

	assign addr_neg = '0 - addr_s1;   // 2^AB - addr, upper half only
	assign tan_idx  = addr_s1[AB-1] ? addr_neg[AB-2:0] : addr_s1[AB-2:0];

	always_comb begin
		if (wave_s1 == tosc_pkg::WAVE_SINE[0]) begin
			neg_d = addr_s1[AB-1];
			if (addr_s1[AB-2]) mag_d = MW'(cos_rom[addr_s1[AB-3:0]]);
			else               mag_d = MW'(sin_rom[addr_s1[AB-3:0]]);
		end else if (addr_s1 == AB'(HN)) begin
			// pole of the tangent
			neg_d = 1'b0;
			mag_d = tosc_pkg::TAN_LIMIT;
		end else begin
			neg_d = addr_s1[AB-1];
			mag_d = tan_rom[tan_idx];
		end
		if (mute_s1) mag_d = '0;
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			mag_s2   <= mag_d;
			neg_s2   <= neg_d;
			level_s2 <= level_s1;
		end
	end

	// ---------------- stage 3: level scaling ----------------
	logic [MW+15:0] prod_lvl;
	logic [MW:0]    scaled;
	logic [31:0]    m_s3;
	logic           neg_s3;

	assign prod_lvl = {16'd0, mag_s2} * {{MW{1'b0}}, level_s2};
	assign scaled   = prod_lvl[MW+15:15];

	always_ff @(posedge clk) begin
		if (rdy3) begin
			m_s3   <= (scaled > (MW+1)'(64'd1 << 31)) ? 32'h8000_0000 : scaled[31:0];
			neg_s3 <= neg_s2;
		end
	end

	// ---------------- output: full scale, saturate, sign ----------------
	logic [46:0] fs_prod;
	logic [16:0] fs_val;
	logic [14:0] fs_sat;

	assign fs_prod = {m_s3, 15'd0} - {15'd0, m_s3};   // m * 32767
	assign fs_val  = fs_prod[46:30];
	assign fs_sat  = (fs_val > 17'(tosc_pkg::FULL_SCALE)) ? tosc_pkg::FULL_SCALE
	                                                      : fs_val[14:0];

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			sample <= neg_s3 ? -$signed({1'b0, fs_sat}) : $signed({1'b0, fs_sat});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			sample_valid <= 1'b0;
		end else begin
			if (rdy1)    v_s1         <= acc & (kind == tosc_pkg::KIND_TICK);
			if (rdy2)    v_s2         <= v_s1;
			if (rdy3)    v_s3         <= v_s2;
			if (rdy_out) sample_valid <= v_s3;
		end
	end

endmodule

`default_nettype wire
